>>> rtl/hpl_pkg.sv
// ----------------------------------------------------------------------------
// hpl_pkg: shared types and constants for the histogram percentile levels block
// Widths, level constants, controller states and the command/status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package hpl_pkg;

    // Histogram bin and running total width
    localparam int COUNT_BITS = 20;
    localparam int LEVEL_W    = 8;
    localparam int NUM_BINS   = 1 << LEVEL_W;
    localparam int LIMIT_W    = 20;
    localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LEVEL_W-1:0]    LEVEL_TOP = {LEVEL_W{1'b1}};
    localparam logic [LEVEL_W-1:0]    LEVEL_MIN = LEVEL_W'(1);

    // Configuration register map (word index)
    localparam logic REG_FIRST_LIMIT  = 1'b0;
    localparam logic REG_SECOND_LIMIT = 1'b1;
    localparam logic [LIMIT_W-1:0] FIRST_LIMIT_RST  = LIMIT_W'(15440);
    localparam logic [LIMIT_W-1:0] SECOND_LIMIT_RST = LIMIT_W'(23160);

    // Result item layout
    localparam int RESULT_W  = 2 * LEVEL_W + 2;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SCAN,
        ST_RESULT
    } hpl_state_t;

    typedef struct packed {
        logic pix_accept;
        logic scan_init;
        logic scan_run;
        logic result_load;
        logic frame_clear;
    } hpl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_full;
    } hpl_stat_t;

endpackage

>>> rtl/hpl_ram.sv
// ----------------------------------------------------------------------------
// hpl_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port (returns old data on a same-address write)
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/hpl_ctrl.sv
// ----------------------------------------------------------------------------
// hpl_ctrl: frame controller
// Sequences pixel collection, the level scan and the hand-off of the result.
// ----------------------------------------------------------------------------
module hpl_ctrl
    import hpl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  hpl_stat_t stat,
    output hpl_cmd_t  cmd
);

    hpl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_tvalid && s_tlast) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!stat.out_full) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready        = 1'b0;
        cmd.pix_accept  = 1'b0;
        cmd.scan_init   = 1'b0;
        cmd.scan_run    = 1'b0;
        cmd.result_load = 1'b0;
        cmd.frame_clear = 1'b0;
        case (state_reg)
            ST_COLLECT: begin
                s_tready       = 1'b1;
                cmd.pix_accept = s_tvalid;
                cmd.scan_init  = s_tvalid && s_tlast;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
            end
            ST_RESULT: begin
                cmd.result_load = !stat.out_full;
                cmd.frame_clear = !stat.out_full;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/hpl_datapath.sv
// ----------------------------------------------------------------------------
// hpl_datapath: histogram update and level scan
// Counts pixels into the bin RAM with read-modify-write forwarding, then
// walks the bins downward accumulating a saturating total for both searches.
// ----------------------------------------------------------------------------
module hpl_datapath
    import hpl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hpl_cmd_t              cmd,
    output hpl_stat_t             stat,
    input  logic [LEVEL_W-1:0]    s_pixel,
    input  logic [LIMIT_W-1:0]    first_limit,
    input  logic [LIMIT_W-1:0]    second_limit,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // Read stage
    logic                  s_pix_vld_reg;
    logic                  s_scan_vld_reg;
    logic [LEVEL_W-1:0]    s_addr_reg;
    // Last write, kept for forwarding
    logic                  wb_vld_reg;
    logic [LEVEL_W-1:0]    wb_addr_reg;
    logic [COUNT_BITS-1:0] wb_data_reg;
    // Bins written since the last clear
    logic [NUM_BINS-1:0]   hist_vld_reg;
    // Scan state
    logic                  issue_on_reg;
    logic [LEVEL_W-1:0]    issue_level_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic                  phase2_reg;
    logic                  done_reg;
    logic [LEVEL_W-1:0]    lvl1_reg;
    logic                  found1_reg;
    logic [LEVEL_W-1:0]    lvl2_reg;
    logic                  found2_reg;
    // Result register
    logic                  m_tvalid_reg;
    logic [RESULT_W-1:0]   m_data_reg;

    logic                  issue_go;
    logic                  rd_en;
    logic [LEVEL_W-1:0]    rd_addr;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] bin_val;
    logic [COUNT_BITS-1:0] bin_inc;
    logic [COUNT_BITS:0]   tot_sum;
    logic [COUNT_BITS-1:0] tot_sat;
    logic [LIMIT_W-1:0]    limit_sel;
    logic                  hit;
    logic                  acc_en;

    // Pick the bin RAM read address: incoming pixel or scan level
    assign issue_go = cmd.scan_run && issue_on_reg && !done_reg;
    assign rd_en    = cmd.pix_accept || issue_go;
    assign rd_addr  = cmd.pix_accept ? s_pixel : issue_level_reg;

    hpl_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (s_pix_vld_reg),
        .wr_addr (s_addr_reg),
        .wr_data (bin_inc),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Resolve the bin value: forwarded write, RAM data, or zero if unwritten
    always_comb begin
        if (wb_vld_reg && (wb_addr_reg == s_addr_reg)) begin
            bin_val = wb_data_reg;
        end else if (hist_vld_reg[s_addr_reg]) begin
            bin_val = rd_data;
        end else begin
            bin_val = '0;
        end
    end

    // Saturating increment for a pixel and saturating total for the scan
    assign bin_inc   = (bin_val == COUNT_MAX) ? COUNT_MAX : bin_val + COUNT_BITS'(1);
    assign tot_sum   = {1'b0, total_reg} + {1'b0, bin_val};
    assign tot_sat   = tot_sum[COUNT_BITS] ? COUNT_MAX : tot_sum[COUNT_BITS-1:0];
    assign limit_sel = phase2_reg ? second_limit : first_limit;
    assign hit       = CMP_W'(tot_sat) > CMP_W'(limit_sel);
    assign acc_en    = s_scan_vld_reg && !done_reg;

    // Read stage and write-back tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_pix_vld_reg  <= 1'b0;
            s_scan_vld_reg <= 1'b0;
            wb_vld_reg     <= 1'b0;
            hist_vld_reg   <= '0;
        end else begin
            s_pix_vld_reg  <= cmd.pix_accept;
            s_scan_vld_reg <= issue_go;
            if (cmd.frame_clear) begin
                wb_vld_reg   <= 1'b0;
                hist_vld_reg <= '0;
            end else if (s_pix_vld_reg) begin
                wb_vld_reg               <= 1'b1;
                hist_vld_reg[s_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            s_addr_reg <= rd_addr;
        end
        if (s_pix_vld_reg) begin
            wb_addr_reg <= s_addr_reg;
            wb_data_reg <= bin_inc;
        end
    end

    // Scan: issue levels downward, accumulate, record both levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_on_reg    <= 1'b0;
            issue_level_reg <= LEVEL_TOP;
            total_reg       <= '0;
            phase2_reg      <= 1'b0;
            done_reg        <= 1'b0;
            lvl1_reg        <= '0;
            found1_reg      <= 1'b0;
            lvl2_reg        <= '0;
            found2_reg      <= 1'b0;
        end else if (cmd.scan_init) begin
            issue_on_reg    <= 1'b1;
            issue_level_reg <= LEVEL_TOP;
            total_reg       <= '0;
            phase2_reg      <= 1'b0;
            done_reg        <= 1'b0;
            lvl1_reg        <= '0;
            found1_reg      <= 1'b0;
            lvl2_reg        <= '0;
            found2_reg      <= 1'b0;
        end else begin
            if (issue_go) begin
                issue_level_reg <= issue_level_reg - LEVEL_W'(1);
                if (issue_level_reg == LEVEL_MIN) begin
                    issue_on_reg <= 1'b0;
                end
            end
            if (acc_en) begin
                total_reg <= tot_sat;
                if (hit && !phase2_reg) begin
                    lvl1_reg   <= s_addr_reg;
                    found1_reg <= 1'b1;
                    phase2_reg <= 1'b1;
                end
                if (hit && phase2_reg) begin
                    lvl2_reg   <= s_addr_reg;
                    found2_reg <= 1'b1;
                    done_reg   <= 1'b1;
                end
                if (s_addr_reg == LEVEL_MIN) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_data_reg <= {found2_reg, lvl2_reg, found1_reg, lvl1_reg};
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = M_TDATA_W'(m_data_reg);
    assign stat.scan_done = done_reg;
    assign stat.out_full  = m_tvalid_reg && !m_tready;

    // A second level is only ever found below a found first level
    a_found2_needs_found1: assert property (@(posedge aclk) disable iff (!aresetn)
        found2_reg |-> (found1_reg && (lvl2_reg < lvl1_reg)))
        else $error("second level found without a higher first level");

    // Pixel writes and scan reads never share the read stage
    a_stage_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_pix_vld_reg && s_scan_vld_reg))
        else $error("pixel and scan both in read stage");

    // A frame clear empties the histogram
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.frame_clear |=> ((hist_vld_reg == '0) && !wb_vld_reg))
        else $error("histogram not empty after frame clear");

    // Level 0 is never scanned
    a_no_level_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_scan_vld_reg |-> (s_addr_reg != '0))
        else $error("scan reached level 0");

endmodule

>>> rtl/histogram_percentile_levels.sv
// ----------------------------------------------------------------------------
// histogram_percentile_levels: frame histogram with two count-limit levels
// Builds a 256-bin histogram of a pixel stream and, at the end of each frame,
// finds the intensity levels where the top-down pixel count passes two limits.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while a frame is collected. After the pixel
// marked with s_tlast, the block stops taking pixels and scans the histogram
// RAM from level 255 down, one bin per cycle through its single read port.
// The scan reads at most 255 bins, levels 255 down to 1, and the result item
// is then loaded into the output register; s_tready stays low meanwhile. If
// the previous result item has not been taken by then, both wait until it is.
// The histogram is empty after reset and after every frame, with no clearing
// pass. One result item is sent per frame and is held in an output register.
// A new frame is collected while it waits, but the following result waits
// until it has been taken.
module histogram_percentile_levels
    import hpl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Pixel input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel
    input  logic                 s_tlast,
    // Result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] first_level, [8] first_found,
                                            // [16:9] second_level, [17] second_found
    // Configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    hpl_cmd_t            cmd;
    hpl_stat_t           stat;
    logic [LIMIT_W-1:0]  first_limit_reg;
    logic [LIMIT_W-1:0]  second_limit_reg;
    logic                cfg_wr;

    // Register writes: word select on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_limit_reg  <= FIRST_LIMIT_RST;
            second_limit_reg <= SECOND_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FIRST_LIMIT:  first_limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_SECOND_LIMIT: second_limit_reg <= pwdata[LIMIT_W-1:0];
                default:          first_limit_reg  <= first_limit_reg;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[2])
            REG_FIRST_LIMIT:  prdata = 32'(first_limit_reg);
            REG_SECOND_LIMIT: prdata = 32'(second_limit_reg);
            default:          prdata = '0;
        endcase
    end

    hpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hpl_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_pixel      (s_tdata),
        .first_limit  (first_limit_reg),
        .second_limit (second_limit_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

>>> verif/percentile_level_checker.sv
// ----------------------------------------------------------------------------
// percentile_level_checker: result checker for histogram_percentile_levels
// Watches the pixel, result and register ports. It keeps its own histogram
// and limit registers, works out the two levels at the end of each frame, and
// compares each result item with the oldest level pair still waiting.
// ----------------------------------------------------------------------------
module percentile_level_checker
    import hpl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] pixel
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [7:0] first_level, [8] first_found,
                                            // [16:9] second_level, [17] second_found
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   mismatch_count,
    output int                   pending_results
);

    // One result item, first field in the lowest bits
    typedef struct packed {
        logic               second_found;
        logic [LEVEL_W-1:0] second_level;
        logic               first_found;
        logic [LEVEL_W-1:0] first_level;
    } levels_t;

    logic [COUNT_BITS-1:0] pixel_hist [NUM_BINS];
    logic [LIMIT_W-1:0]    first_limit;
    logic [LIMIT_W-1:0]    second_limit;
    levels_t               expected_levels_q [$];

    // Add two counts, clamp at the all-ones value
    function automatic logic [COUNT_BITS-1:0] sat_sum(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    // Scan the histogram from the top level down; level 0 never counts
    function automatic levels_t predict_levels();
        levels_t               r;
        logic [COUNT_BITS-1:0] total;
        int                    lv;
        r     = '0;
        total = '0;
        lv    = NUM_BINS - 1;
        while (lv > 0 && !r.first_found) begin
            total = sat_sum(total, pixel_hist[lv]);
            if (total > first_limit) begin
                r.first_found = 1'b1;
                r.first_level = lv[LEVEL_W-1:0];
            end
            lv--;
        end
        // Carry the total on, starting one level below the first level
        if (r.first_found) begin
            while (lv > 0 && !r.second_found) begin
                total = sat_sum(total, pixel_hist[lv]);
                if (total > second_limit) begin
                    r.second_found = 1'b1;
                    r.second_level = lv[LEVEL_W-1:0];
                end
                lv--;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : monitor
        levels_t got;
        levels_t want;
        if (!aresetn) begin
            for (int b = 0; b < NUM_BINS; b++) pixel_hist[b] = '0;
            first_limit  = FIRST_LIMIT_RST;
            second_limit = SECOND_LIMIT_RST;
            expected_levels_q.delete();
            mismatch_count = 0;
        end else begin
            // Track limit register writes
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (paddr[2])
                    REG_FIRST_LIMIT:  first_limit  = pwdata[LIMIT_W-1:0];
                    REG_SECOND_LIMIT: second_limit = pwdata[LIMIT_W-1:0];
                    default:          ;
                endcase
            end
            // Count the pixel; on the last one predict and start a fresh frame
            if (s_tvalid && s_tready) begin
                pixel_hist[s_tdata] = sat_sum(pixel_hist[s_tdata], COUNT_BITS'(1));
                if (s_tlast) begin
                    expected_levels_q.push_back(predict_levels());
                    for (int b = 0; b < NUM_BINS; b++) pixel_hist[b] = '0;
                end
            end
            // Compare each result item with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = levels_t'(m_tdata[RESULT_W-1:0]);
                if (expected_levels_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none actual %h", $time, m_tdata);
                end else begin
                    want = expected_levels_q.pop_front();
                    check_field("first_level", want.first_level, got.first_level);
                    check_field("first_found", 8'(want.first_found), 8'(got.first_found));
                    check_field("second_level", want.second_level, got.second_level);
                    check_field("second_found", 8'(want.second_found),
                                8'(got.second_found));
                end
            end
        end
        pending_results = expected_levels_q.size();
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for histogram_percentile_levels
// Drives pixel frames and limit register writes, toggles backpressure, and
// leaves all result checking to percentile_level_checker.
// ----------------------------------------------------------------------------
module testbench;
    import hpl_pkg::*;

    localparam int SCAN_HOLDOFF = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [2:0]           paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int mismatch_count;
    int pending_results;
    int sender_idle_pct = 18;
    int recv_idle_pct   = 63;
    int cycle_count     = 0;

    histogram_percentile_levels uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    percentile_level_checker level_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random backpressure on the result channel
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one pixel item after any idle cycles, and wait for the handshake
    task automatic send_pixel(input logic [7:0] px, input logic lst);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Hold off the sender until every predicted result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
    endtask

    task automatic write_limit(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Go idle, let any scan finish, then load both limits
    task automatic set_limits(input logic [31:0] first_v, input logic [31:0] second_v);
        drain_results();
        repeat (SCAN_HOLDOFF) @(negedge aclk);
        write_limit(REG_FIRST_LIMIT, first_v);
        write_limit(REG_SECOND_LIMIT, second_v);
    endtask

    // Send one frame of random length with one of several pixel spreads
    task automatic send_frame(inout int sent);
        int         len;
        int         spread;
        int         center;
        int         t;
        logic [7:0] px;
        len    = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        spread = $urandom_range(3);
        center = $urandom_range(255);
        for (int i = 0; i < len; i++) begin
            case (spread)
                0: px = 8'($urandom_range(255));
                1: begin
                    t = center + int'($urandom_range(16)) - 8;
                    if (t < 0) t = 0;
                    if (t > 255) t = 255;
                    px = t[7:0];
                end
                2: px = $urandom_range(1) ? 8'($urandom_range(1))
                                          : 8'(254 + $urandom_range(1));
                default: px = 8'($urandom_range(3));
            endcase
            send_pixel(px, i == len - 1);
        end
        sent += len;
    endtask

    initial begin : stimulus
        int sent;
        int lim1;
        int lim2;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset limits are far above a short frame: nothing found
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd7, 1'b1);
        send_pixel(8'd0, 1'b1);

        // Zero limits: any counted pixel passes
        set_limits(32'd0, 32'd0);
        send_pixel(8'd200, 1'b1);       // second level is the one just below
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd3, 1'b1);
        send_pixel(8'd1, 1'b1);         // first level 1 leaves no room below
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b1);         // level 0 never counts
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd4, 1'b1);         // first limit passed at level 9, second at level 8

        // Top first limit (upper bits dropped): second search never runs
        set_limits(32'hFFFF_FFFF, 32'd0);
        send_pixel(8'd170, 1'b0);
        send_pixel(8'd85, 1'b0);
        send_pixel(8'd15, 1'b1);

        // Top second limit: first found, second not
        set_limits(32'd2, 32'h000F_FFFF);
        send_pixel(8'd240, 1'b0);
        send_pixel(8'd240, 1'b0);
        send_pixel(8'd16, 1'b0);
        send_pixel(8'd1, 1'b1);

        // Random frames under three backpressure patterns
        for (int mode = 0; mode < 3; mode++) begin
            sender_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 63 : 0;
            recv_idle_pct   = (mode == 0) ? 63 : (mode == 1) ? 18 : 0;
            for (int ph = 0; ph < 3; ph++) begin
                lim1 = $urandom_range(12);
                lim2 = $urandom_range(1) ? lim1 + int'($urandom_range(15))
                                         : int'($urandom_range(12));
                set_limits(32'(lim1), 32'(lim2));
                sent = 0;
                while (sent < 92) begin
                    send_frame(sent);
                    if ($urandom_range(7) == 0) drain_results();
                end
            end
        end

        // Let the last results come out, then give the verdict
        drain_results();
        repeat (SCAN_HOLDOFF) @(negedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
